@@ rtl/kgbd_pkg.sv @@
package kgbd_pkg;

    localparam int unsigned CountW = 32;
    localparam int unsigned BytesW = 48;
    localparam int unsigned FrameW = 24;
    localparam int unsigned SecW   = 16;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [SecW-1:0] SecMax = '1;

    // item kinds
    typedef enum logic [1:0] {
        OP_FRAME   = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    // per-item decision codes
    typedef enum logic [2:0] {
        V_FORWARD       = 3'd0,
        V_NOT_RUNNING   = 3'd1,
        V_PRE_KEY       = 3'd2,
        V_PRESSURE_DROP = 3'd3,
        V_STALL_KILL    = 3'd4,
        V_NON_FRAME     = 3'd5
    } t_verdict;

    // register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_HIGH_MARK   = 2'd0,
        CFG_LOW_MARK    = 2'd1,
        CFG_STALL_LIMIT = 2'd2,
        CFG_TEST        = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0]     high_mark;
        logic [31:0]     low_mark;
        logic [SecW-1:0] stall_limit;
        logic            test_pressure;
    } t_cfg;

    typedef struct packed {
        logic              awaiting_key;
        logic              pressure;
        logic [SecW-1:0]   secs;
        logic [CountW-1:0] drop_total;
        logic [CountW-1:0] sent_total;
        logic [BytesW-1:0] byte_total;
    } t_state;

    typedef struct packed {
        logic [1:0]        op;
        logic              is_keyframe;
        logic [31:0]       buffered_bytes;
        logic [FrameW-1:0] frame_bytes;
        logic              pipe_running;
    } t_item;

    typedef struct packed {
        t_verdict          verdict;
        logic              pressure_on;
        logic [CountW-1:0] dropped_count;
        logic [CountW-1:0] sent_count;
        logic [BytesW-1:0] forwarded_bytes;
    } t_result;

    localparam t_cfg CfgReset = '{
        high_mark:     32'd1048576,
        low_mark:      32'd131072,
        stall_limit:   16'd10,
        test_pressure: 1'b0
    };

    localparam t_state StateReset = '{
        awaiting_key: 1'b1,
        pressure:     1'b0,
        secs:         '0,
        drop_total:   '0,
        sent_total:   '0,
        byte_total:   '0
    };

endpackage

@@ rtl/kgbd_decide.sv @@
module kgbd_decide
    import kgbd_pkg::*;
(
    input  t_cfg     i_cfg,
    input  t_state   i_state,
    input  t_item    i_item,
    output t_state   o_state,
    output t_result  o_result
);

    logic [32:0] w_level;
    logic        w_forward;
    t_verdict    w_verdict;
    t_state      w_next;

    // effective buffered level, 33 bits so it never wraps
    assign w_level = {1'b0, i_item.buffered_bytes}
                   + ((i_cfg.test_pressure && !i_item.is_keyframe)
                      ? {1'b0, i_cfg.high_mark} : 33'd0);

    // next state and verdict for one request
    always_comb begin
        w_next    = i_state;
        w_verdict = V_NON_FRAME;
        w_forward = 1'b0;
        case (t_op'(i_item.op))
            OP_FRAME: begin
                if (!i_item.pipe_running) begin
                    w_verdict = V_NOT_RUNNING;
                end else if (i_state.awaiting_key && !i_item.is_keyframe) begin
                    w_verdict = V_PRE_KEY;
                end else begin
                    w_next.awaiting_key = 1'b0;
                    if (i_state.pressure) begin
                        if (i_state.secs >= i_cfg.stall_limit) begin
                            w_verdict = V_STALL_KILL;
                        end else if (w_level < {1'b0, i_cfg.low_mark}) begin
                            // pressure relieved, episode ends
                            w_next.pressure   = 1'b0;
                            w_next.secs       = '0;
                            w_next.drop_total = '0;
                            w_forward         = 1'b1;
                        end else if (!i_item.is_keyframe) begin
                            w_next.drop_total = i_state.drop_total + 1'b1;
                            w_verdict         = V_PRESSURE_DROP;
                        end else begin
                            w_forward = 1'b1;
                        end
                    end else if (w_level > {1'b0, i_cfg.high_mark}) begin
                        // episode starts on this frame
                        w_next.pressure   = 1'b1;
                        w_next.secs       = '0;
                        w_next.drop_total = i_state.drop_total + 1'b1;
                        w_verdict         = V_PRESSURE_DROP;
                    end else begin
                        w_forward = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (i_state.secs != SecMax) begin
                    w_next.secs = i_state.secs + 1'b1;
                end
            end
            OP_RESTART: begin
                w_next = StateReset;
            end
            default: begin
            end
        endcase

        if (w_forward) begin
            w_verdict         = V_FORWARD;
            w_next.sent_total = w_next.sent_total + 1'b1;
            w_next.byte_total = w_next.byte_total
                              + {{(BytesW-FrameW){1'b0}}, i_item.frame_bytes};
        end
    end

    assign o_state                  = w_next;
    assign o_result.verdict         = w_verdict;
    assign o_result.pressure_on     = w_next.pressure;
    assign o_result.dropped_count   = w_next.drop_total;
    assign o_result.sent_count      = w_next.sent_total;
    assign o_result.forwarded_bytes = w_next.byte_total;

endmodule

@@ rtl/keyframe_gated_backpressure_dropper.sv @@
// Frame dropper with keyframe gating and hysteresis backpressure. Every
// accepted request (frame, one-second tick or session restart) yields exactly
// one result carrying the verdict and the session counters after that item.
// One request is taken every cycle: the decision is a single pass of compare
// and add logic (a 33-bit level add and compare, a 48-bit byte total add)
// from the session state registers, and the result lands in an output register
// backed by one skid entry, so o_in_stall rises only when both are full.
// Registers are to be written through the plain write port only while the block
// is idle; the block itself does not enforce this. A restart clears the session
// but keeps the registers.
module keyframe_gated_backpressure_dropper
    import kgbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CfgIdxW-1:0]   i_cfg_index,
    input  logic [31:0]          i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_op,
    input  logic                 i_is_keyframe,
    input  logic [31:0]          i_buffered_bytes,
    input  logic [FrameW-1:0]    i_frame_bytes,
    input  logic                 i_pipe_running,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_verdict,
    output logic                 o_pressure_on,
    output logic [CountW-1:0]    o_dropped_count,
    output logic [CountW-1:0]    o_sent_count,
    output logic [BytesW-1:0]    o_forwarded_bytes
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   w_item;
    t_result w_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    w_in_acc;
    logic    w_out_take;

    assign w_item = '{
        op:             i_op,
        is_keyframe:    i_is_keyframe,
        buffered_bytes: i_buffered_bytes,
        frame_bytes:    i_frame_bytes,
        pipe_running:   i_pipe_running
    };

    assign o_in_stall = r_skid_valid;
    assign w_in_acc   = i_in_valid && !r_skid_valid;
    assign w_out_take = r_out_valid && !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CfgReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HIGH_MARK:   r_cfg.high_mark     <= i_cfg_data;
                CFG_LOW_MARK:    r_cfg.low_mark      <= i_cfg_data;
                CFG_STALL_LIMIT: r_cfg.stall_limit   <= i_cfg_data[SecW-1:0];
                CFG_TEST:        r_cfg.test_pressure <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    kgbd_decide u_decide (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (w_item),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // session state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StateReset;
        end else if (w_in_acc) begin
            r_state <= n_state;
        end
    end

    // output register and skid entry control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_acc) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out <= r_skid;
            end
        end else if (w_in_acc) begin
            if (!r_out_valid || w_out_take) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_verdict         = r_out.verdict;
    assign o_pressure_on     = r_out.pressure_on;
    assign o_dropped_count   = r_out.dropped_count;
    assign o_sent_count      = r_out.sent_count;
    assign o_forwarded_bytes = r_out.forwarded_bytes;

    // skid entry only holds data behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // draining the skid entry leaves output full and skid empty
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry did not drain into output register");

    // a restart leaves a fresh session
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_op == OP_RESTART) |=>
        (r_state.awaiting_key && !r_state.pressure && r_state.sent_total == '0
         && r_state.byte_total == '0 && r_state.drop_total == '0))
        else $error("restart did not clear session state");

    // apart from a restart, only forwarded frames move the sent and byte totals
    a_totals_only_on_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_result.verdict != V_FORWARD && i_op != OP_RESTART) |=>
        (r_state.sent_total == $past(r_state.sent_total)
         && r_state.byte_total == $past(r_state.byte_total)))
        else $error("totals changed on a non-forwarded item");

endmodule
